### rtl/core/sfia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfia_pkg;

  // Store limits and the largest primitive that one header may open.
  localparam int unsigned MaxVerts     = 2048;
  localparam int unsigned MaxIndices   = 4096;
  localparam int unsigned MaxPrimVerts = 66;

  localparam int unsigned ScaleW  = 17;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned IdxW    = 11;
  localparam int unsigned BaseW   = 12;
  localparam int unsigned TotalW  = 13;
  localparam int unsigned LeftW   = 7;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned InDataW = 64;

  localparam logic [ScaleW-1:0] ScaleOne = 17'h10000;

  typedef enum logic [1:0] {
    KindTri = 2'd0,
    KindVtx = 2'd1,
    KindSum = 2'd2,
    KindErr = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ErrOverflow = 2'd0,
    ErrHeader   = 2'd1,
    ErrStray    = 2'd2
  } err_e;

  // Result payload, lowest field in the lowest bits.
  typedef struct packed {
    logic              pad;
    logic [1:0]        error_code;
    logic [BaseW-1:0]  total_vertices;
    logic [TotalW-1:0] total_indices;
    logic [ProdW-1:0]  t_out;
    logic [ProdW-1:0]  s_out;
    logic [IdxW-1:0]   src_vertex;
    logic [IdxW-1:0]   idx_c;
    logic [IdxW-1:0]   idx_b;
    logic [IdxW-1:0]   idx_a;
  } result_t;

  localparam int unsigned OutDataW = $bits(result_t);

endpackage

`default_nettype wire

### rtl/core/strip_fan_index_assembler_unit.sv
// Vertex record: scaled in StMulS then StMulT (two passes through the shared multiplier),
// then held in StEmit until the output register is free; the next item waits for that.
// Header: checked in StCheck, then triangles follow one per cycle while the output is
// taken; the next item can be taken in the cycle after the last triangle is loaded.
// Summaries and errors pass StCheck, then StEmit; a one- or two-vertex header emits none.
// rst_ni is asynchronous and active low; it clears the counters, sets both scales to 1.0.
`timescale 1ns / 1ps
`default_nettype none

module strip_fan_index_assembler_unit (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // Configuration write channel.
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire                           cfg_index_i,
  input  wire [sfia_pkg::ScaleW-1:0]    cfg_data_i,
  // Input items.
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: prim_count[15:0], vertex_ref[26:16], tex_s_in[42:27], tex_t_in[58:43], zeros.
  input  wire [sfia_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: cmd.
  input  wire                           s_axis_tuser,
  // Result items.
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // tdata: idx_a[10:0], idx_b[21:11], idx_c[32:22], src_vertex[43:33], s_out[75:44],
  // t_out[107:76], total_indices[120:108], total_vertices[132:121], error_code[134:133].
  output logic [sfia_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: kind.
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast
);

  import sfia_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StCheck = 6'b000010,
    StMulS  = 6'b000100,
    StMulT  = 6'b001000,
    StTri   = 6'b010000,
    StEmit  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [ScaleW-1:0] s_scale_q, s_scale_d, t_scale_q, t_scale_d;
  logic [BaseW-1:0]  base_q, base_d;
  logic [TotalW-1:0] itotal_q, itotal_d;
  logic [LeftW-1:0]  left_q, left_d;

  // Latched input item.
  logic              cmd_q, cmd_d;
  logic              fan_q, fan_d;
  logic [16:0]       n_q, n_d;
  logic [IdxW-1:0]   vref_q, vref_d;
  logic [CoordW-1:0] tex_s_q, tex_s_d, tex_t_q, tex_t_d;

  // Triangle sequencing.
  logic [LeftW-1:0]  tri_i_q, tri_i_d, tris_q, tris_d;

  // Staged single result.
  result_t           res_q, res_d;
  logic [1:0]        res_kind_q, res_kind_d;

  // Output register.
  logic              ov_q, ov_d;
  result_t           od_q, od_d;
  logic [1:0]        ok_q, ok_d;
  logic              ol_q, ol_d;

  logic              out_free;
  assign out_free = !ov_q || m_axis_tready;

  // Shared multiplier: one coordinate times its clamped scale per cycle.
  logic [CoordW-1:0]      mul_coord;
  logic [ScaleW-1:0]      mul_scale, mul_k;
  logic signed [33:0]     prod;
  assign mul_coord = (state_q == StMulS) ? tex_s_q : tex_t_q;
  assign mul_scale = (state_q == StMulS) ? s_scale_q : t_scale_q;
  assign mul_k     = mul_scale[ScaleW-1] ? ScaleOne : mul_scale;
  assign prod      = $signed(mul_coord) * $signed({1'b0, mul_k});

  // Header checks.
  logic [16:0]       prim_ext, prim_abs;
  logic [LeftW-1:0]  n7, tris_c;
  logic [8:0]        add_idx;
  logic [TotalW:0]   idx_sum;
  logic [BaseW:0]    vtx_sum;
  assign prim_ext = {s_axis_tdata[15], s_axis_tdata[15:0]};
  assign prim_abs = prim_ext[16] ? (~prim_ext + 17'd1) : prim_ext;
  assign n7       = n_q[LeftW-1:0];
  assign tris_c   = (n7 >= 7'd3) ? (n7 - 7'd2) : '0;
  assign add_idx  = {1'b0, tris_c, 1'b0} + {2'b0, tris_c};
  assign idx_sum  = {1'b0, itotal_q} + {5'b0, add_idx};
  assign vtx_sum  = {1'b0, base_q} + {6'b0, n7};

  // Triangle index generation.
  logic [IdxW-1:0] bi, p1, p2;
  result_t         tri_res;
  assign bi = base_q[IdxW-1:0] + {4'b0, tri_i_q};
  assign p1 = bi + 11'd1;
  assign p2 = bi + 11'd2;
  always_comb begin
    tri_res = '0;
    if (fan_q) begin
      tri_res.idx_a = base_q[IdxW-1:0];
      tri_res.idx_b = p1;
      tri_res.idx_c = p2;
    end else begin
      tri_res.idx_a = bi;
      tri_res.idx_b = tri_i_q[0] ? p2 : p1;
      tri_res.idx_c = tri_i_q[0] ? p1 : p2;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ok_q;
  assign m_axis_tlast  = ol_q;

  always_comb begin
    state_d    = state_q;
    s_scale_d  = s_scale_q;
    t_scale_d  = t_scale_q;
    base_d     = base_q;
    itotal_d   = itotal_q;
    left_d     = left_q;
    cmd_d      = cmd_q;
    fan_d      = fan_q;
    n_d        = n_q;
    vref_d     = vref_q;
    tex_s_d    = tex_s_q;
    tex_t_d    = tex_t_q;
    tri_i_d    = tri_i_q;
    tris_d     = tris_q;
    res_d      = res_q;
    res_kind_d = res_kind_q;
    ov_d       = ov_q;
    od_d       = od_q;
    ok_d       = ok_q;
    ol_d       = ol_q;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    if (cfg_valid_i) begin
      if (cfg_index_i) begin
        t_scale_d = cfg_data_i;
      end else begin
        s_scale_d = cfg_data_i;
      end
    end

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          cmd_d   = s_axis_tuser;
          fan_d   = s_axis_tdata[15];
          n_d     = prim_abs;
          vref_d  = s_axis_tdata[26:16];
          tex_s_d = s_axis_tdata[42:27];
          tex_t_d = s_axis_tdata[58:43];
          state_d = StCheck;
        end
      end
      StCheck: begin
        res_d      = '0;
        res_kind_d = KindErr;
        state_d    = StEmit;
        if (cmd_q) begin
          if (left_q == '0) begin
            res_d.error_code = ErrStray;
          end else begin
            res_kind_d = KindVtx;
            res_d.src_vertex = vref_q;
            state_d = StMulS;
          end
        end else if (left_q != '0) begin
          res_d.error_code = ErrHeader;
        end else if (n_q == '0) begin
          res_kind_d           = KindSum;
          res_d.total_indices  = itotal_q;
          res_d.total_vertices = base_q;
          base_d   = '0;
          itotal_d = '0;
        end else if (n_q > 17'(MaxPrimVerts) || vtx_sum > 13'(MaxVerts) ||
                     idx_sum > 14'(MaxIndices)) begin
          res_d.error_code = ErrOverflow;
        end else begin
          itotal_d = idx_sum[TotalW-1:0];
          left_d   = n7;
          tris_d   = tris_c;
          tri_i_d  = '0;
          state_d  = (tris_c == '0) ? StIdle : StTri;
        end
      end
      StMulS: begin
        res_d.s_out = prod[ProdW-1:0];
        state_d     = StMulT;
      end
      StMulT: begin
        res_d.t_out = prod[ProdW-1:0];
        base_d      = base_q + 12'd1;
        left_d      = left_q - 7'd1;
        state_d     = StEmit;
      end
      StTri: begin
        if (out_free) begin
          ov_d = 1'b1;
          od_d = tri_res;
          ok_d = KindTri;
          ol_d = (tri_i_q + 7'd1 == tris_q);
          tri_i_d = tri_i_q + 7'd1;
          if (tri_i_q + 7'd1 == tris_q) begin
            state_d = StIdle;
          end
        end
      end
      StEmit: begin
        if (out_free) begin
          ov_d    = 1'b1;
          od_d    = res_q;
          ok_d    = res_kind_q;
          ol_d    = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      s_scale_q <= ScaleOne;
      t_scale_q <= ScaleOne;
      base_q    <= '0;
      itotal_q  <= '0;
      left_q    <= '0;
      tri_i_q   <= '0;
      tris_q    <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      s_scale_q <= s_scale_d;
      t_scale_q <= t_scale_d;
      base_q    <= base_d;
      itotal_q  <= itotal_d;
      left_q    <= left_d;
      tri_i_q   <= tri_i_d;
      tris_q    <= tris_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    fan_q      <= fan_d;
    n_q        <= n_d;
    vref_q     <= vref_d;
    tex_s_q    <= tex_s_d;
    tex_t_q    <= tex_t_d;
    res_q      <= res_d;
    res_kind_q <= res_kind_d;
    od_q       <= od_d;
    ok_q       <= ok_d;
    ol_q       <= ol_d;
  end

endmodule

`default_nettype wire

### rtl/core/sfia_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sfia_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           s_axis_tvalid,
  input wire                           s_axis_tready,
  input wire                           m_axis_tvalid,
  input wire                           m_axis_tready,
  input wire [sfia_pkg::OutDataW-1:0]  m_axis_tdata,
  input wire [1:0]                     m_axis_tuser,
  input wire                           m_axis_tlast
);

  import sfia_pkg::*;

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Every result other than a triangle is marked last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KindTri) |-> m_axis_tlast)
    else $error("single result without last");

  // A triangle carries only its three indices.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KindTri) |-> (m_axis_tdata[OutDataW-1:33] == '0))
    else $error("triangle with stray fields");

  // Error codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KindErr) |->
      (m_axis_tdata[134:133] == ErrOverflow || m_axis_tdata[134:133] == ErrHeader ||
       m_axis_tdata[134:133] == ErrStray))
    else $error("bad error code");

  // The input side never takes two items back to back, whatever their kind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted two items back to back");

endmodule

bind strip_fan_index_assembler_unit sfia_checker u_sfia_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
